### hdl/mm3_pkg.sv
// Murmur3 x86 32-bit hash: shared constants and types.
// No dependencies; imported by every module of the hash engine.
package mm3_pkg;

    localparam logic [31:0] MM3_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM3_C2  = 32'h1b873593;
    localparam logic [31:0] MM3_ADD = 32'he6546b64;
    localparam logic [31:0] MM3_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM3_F2  = 32'hc2b2ae35;
    localparam logic [31:0] MM3_M5  = 32'd5;
    localparam logic [31:0] MM3_ONE = 32'd1;

    localparam logic [2:0] MM3_FULL_COUNT = 3'd4;

    // Operand pair sent to the shared multiplier.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mm3_mul_req_t;

    // Finished hash handed from the sequencer to the output register.
    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
    } mm3_result_t;

    function automatic logic [31:0] mm3_rotl(input logic [31:0] x, input int unsigned r);
        mm3_rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

### hdl/mm3_mul.sv
// Shared 32x32 multiplier keeping the low 32 product bits, registered.
// Depends on mm3_pkg for the operand struct.
module mm3_mul import mm3_pkg::*; (
    input  logic         aclk,
    input  mm3_mul_req_t req,
    output logic [31:0]  prod
);

    logic [31:0] prod_reg;
    logic [63:0] full_prod;

    assign full_prod = 64'(req.a) * 64'(req.b);

    always_ff @(posedge aclk) begin
        prod_reg <= full_prod[31:0];
    end

    assign prod = prod_reg;

endmodule

### hdl/mm3_ctrl.sv
// Word sequencer and hash state for the Murmur3 engine; drives the shared multiplier.
// Depends on mm3_pkg.
module mm3_ctrl import mm3_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [31:0]  seed,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  in_word,
    input  logic [2:0]   in_count,
    input  logic         in_last,
    input  logic         out_free,
    output mm3_result_t  res,
    output mm3_mul_req_t mul_req,
    input  logic [31:0]  mul_prod
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_K3   = 3'd3;
    localparam logic [2:0] ST_K4   = 3'd4;
    localparam logic [2:0] ST_FIN0 = 3'd5;
    localparam logic [2:0] ST_FIN1 = 3'd6;
    localparam logic [2:0] ST_FIN2 = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic        active_reg, active_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] k_reg, k_next;
    logic        full_reg, full_next;
    logic        last_reg, last_next;

    logic        accept;
    logic [2:0]  cnt;
    logic        last_eff;
    logic [31:0] masked;
    logic [31:0] h_base;
    logic [31:0] len_base;
    logic [31:0] h_mix;
    logic [31:0] fin_t;
    logic [31:0] fin_u;

    assign in_ready = aresetn && ((state_reg == ST_IDLE) || (state_reg == ST_K4 && !last_reg));
    assign accept   = in_valid && in_ready;

    // Clamp counts above four, and treat any short word as the end of the message.
    assign cnt      = in_count[2] ? MM3_FULL_COUNT : in_count;
    assign last_eff = in_last || (cnt != MM3_FULL_COUNT);

    always_comb begin
        unique case (cnt[1:0])
            2'd1:    masked = {24'd0, in_word[7:0]};
            2'd2:    masked = {16'd0, in_word[15:0]};
            2'd3:    masked = {8'd0, in_word[23:0]};
            default: masked = cnt[2] ? in_word : 32'd0;
        endcase
    end

    assign h_base   = !active_reg ? seed :
                      (state_reg == ST_K4) ? (mul_prod + MM3_ADD) : h_reg;
    assign len_base = active_reg ? len_reg : 32'd0;
    assign h_mix    = h_reg ^ mul_prod;
    assign fin_t    = (h_reg ^ len_reg) ^ ((h_reg ^ len_reg) >> 16);
    assign fin_u    = mul_prod ^ (mul_prod >> 13);

    always_comb begin
        unique case (state_reg)
            ST_K1:   mul_req = '{a: k_reg, b: MM3_C1};
            ST_K2:   mul_req = '{a: mm3_rotl(mul_prod, 15), b: MM3_C2};
            ST_K3:   mul_req = '{a: mm3_rotl(h_mix, 13), b: MM3_M5};
            ST_FIN0: mul_req = '{a: fin_t, b: MM3_F1};
            ST_FIN1: mul_req = '{a: fin_u, b: MM3_F2};
            // Recirculate the product times one: hold the last finalizer product while the
            // output register is still full.
            ST_FIN2: mul_req = '{a: mul_prod, b: MM3_ONE};
            default: mul_req = '{a: k_reg, b: MM3_C1};
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        h_next      = h_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        full_next   = full_reg;
        last_next   = last_reg;
        res.valid   = 1'b0;
        res.hash    = mul_prod ^ (mul_prod >> 16);

        if (accept) begin
            h_next      = h_base;
            len_next    = len_base + {29'd0, cnt};
            k_next      = masked;
            full_next   = (cnt == MM3_FULL_COUNT);
            last_next   = last_eff;
            active_next = 1'b1;
            state_next  = (cnt == 3'd0) ? ST_FIN0 : ST_K1;
        end else begin
            unique case (state_reg)
                ST_IDLE: state_next = ST_IDLE;
                ST_K1:   state_next = ST_K2;
                ST_K2:   state_next = ST_K3;
                ST_K3: begin
                    if (full_reg) begin
                        state_next = ST_K4;
                    end else begin
                        h_next     = h_mix;
                        state_next = last_reg ? ST_FIN0 : ST_IDLE;
                    end
                end
                ST_K4: begin
                    h_next     = mul_prod + MM3_ADD;
                    state_next = last_reg ? ST_FIN0 : ST_IDLE;
                end
                ST_FIN0: state_next = ST_FIN1;
                ST_FIN1: state_next = ST_FIN2;
                ST_FIN2: begin
                    if (out_free) begin
                        res.valid   = 1'b1;
                        active_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        len_reg  <= len_next;
        k_reg    <= k_next;
        full_reg <= full_next;
        last_reg <= last_next;
    end

endmodule

### hdl/murmur3_32_hash_top.sv
// Top level of the Murmur3 x86 32-bit hash engine.
// Depends on mm3_pkg, mm3_mul and mm3_ctrl.

// Murmur3 x86_32 hash over a stream of 32-bit little-endian words. Each
// s_ word carries up to four message bytes (first byte in bits 7:0), a byte
// count and tlast; one hash word comes out on m_ per message. Counts above
// four act as four, and a count below four ends the message even without
// tlast. The seed is written on the cfg_ channel and is loaded at the start
// of the next message. One shared 32x32 multiplier does all the multiplies: a
// full word goes through C1 multiply, C2 multiply, multiply by 5 and add, and
// the next full word is taken in the add step, so a new word is taken only as
// the last one finishes. A partial last word skips the rotate, the multiply
// by 5 and the add. The last word then goes through the finalizer (F1 and F2
// multiplies, final shift-xor) before the hash lands in the output register;
// that register lets the next message start while the hash waits for m_tready.
module murmur3_32_hash_top import mm3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // seed write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // message words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic        s_tlast,
    // hash words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);

    logic [31:0]  seed_reg;
    logic         m_tvalid_reg;
    logic [31:0]  m_tdata_reg;
    logic         out_free;
    mm3_result_t  res;
    mm3_mul_req_t mul_req;
    logic [31:0]  mul_prod;

    // Seed register: writable whenever out of reset, takes effect at the next message start.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            seed_reg <= cfg_data;
        end
    end

    mm3_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    mm3_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .seed     (seed_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_word  (s_tdata[31:0]),
        .in_count (s_tdata[34:32]),
        .in_last  (s_tlast),
        .out_free (out_free),
        .res      (res),
        .mul_req  (mul_req),
        .mul_prod (mul_prod)
    );

    // Output register: load a finished hash when the slot is empty or draining.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_tdata_reg <= res.hash;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/mm3_checker.sv
// Port-level checks for the Murmur3 hash engine, bound to its top level.
// Depends on murmur3_32_hash_top only through its ports.
module mm3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Hold a stalled hash word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("hash word dropped or changed while stalled");

    // Drop ready right after each accepted word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // A new hash comes out of the finalizer only, never while taking input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("hash appeared without a finalize pass");

    // Seed channel never stalls out of reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("seed write stalled");

endmodule

bind murmur3_32_hash_top mm3_checker u_mm3_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

### tb/tb_top.sv
// Self-checking testbench for the Murmur3 x86 32-bit hash engine.
// Depends on mm3_pkg and murmur3_32_hash_top. It drives message words and seed writes,
// predicts each hash and checks every m_ word against that prediction.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mm3_pkg::*;

    localparam int IDLE_PCT      = 14;      // chance per cycle that a side idles
    localparam int SETTLE_CYCLES = 16;      // covers a word, the finalizer and the output reg
    localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest correct run

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] hash_value

    // Predictor state: seed register, hash in progress, byte length of the message.
    logic [31:0] seed_reg  = '0;
    logic [31:0] run_hash  = '0;
    logic [31:0] msg_bytes = '0;
    bit          in_msg    = 1'b0;
    logic [31:0] hash_q[$];        // hashes still owed by the block, oldest first

    int          errors     = 0;
    int          words_sent = 0;
    int          cycles     = 0;
    bit          calm       = 1'b0;  // set during the stretch where neither side idles

    murmur3_32_hash_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rol32(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // Scramble one key word before it is folded into the hash.
    function automatic logic [31:0] scramble_key(logic [31:0] k);
        logic [31:0] t;
        t = k * MM3_C1;
        t = rol32(t, 15);
        t = t * MM3_C2;
        return t;
    endfunction

    // fmix32 avalanche on the final hash.
    function automatic logic [31:0] avalanche(logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * MM3_F1;
        t = t ^ (t >> 13);
        t = t * MM3_F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // Fold one accepted word into the predicted state; queue a hash when it ends a message.
    function automatic void absorb_word(logic [31:0] data, logic [2:0] cnt_in, logic last_in);
        logic [2:0]  cnt;
        logic        ends;
        logic [31:0] h;
        logic [31:0] mask;
        // Counts above four act as four; any short word closes the message.
        cnt  = (cnt_in > MM3_FULL_COUNT) ? MM3_FULL_COUNT : cnt_in;
        ends = last_in || (cnt < MM3_FULL_COUNT);
        if (!in_msg) begin
            run_hash  = seed_reg;
            msg_bytes = '0;
            in_msg    = 1'b1;
        end
        h = run_hash;
        if (cnt == MM3_FULL_COUNT) begin
            h = h ^ scramble_key(data);
            h = rol32(h, 13);
            h = h * MM3_M5 + MM3_ADD;
        end else if (cnt != 3'd0) begin
            // Partial tail: drop the unused upper bytes, skip the rotate-multiply-add.
            mask = (32'd1 << (8 * cnt)) - 32'd1;
            h = h ^ scramble_key(data & mask);
        end
        msg_bytes = msg_bytes + 32'(cnt);
        run_hash  = h;
        if (ends) begin
            hash_q.push_back(avalanche(h ^ msg_bytes));
            in_msg   = 1'b0;
            run_hash = seed_reg;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one word; idle at random first, then hold it until the block takes it.
    // tvalid stays high after acceptance so back-to-back words need no toggle.
    task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic last_in);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, cnt, data};
        s_tlast  <= last_in;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_word(data, cnt, last_in);
        words_sent++;
    endtask

    // Drop tvalid, wait for every owed hash, then let the engine settle.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the seed only once the engine is idle.
    task automatic write_seed(logic [31:0] value);
        hold_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        seed_reg = value;
    endtask

    // Mostly well-formed messages with random content; the rest is noise that
    // mixes clamped counts, short words without tlast and open-ended runs.
    task automatic send_random_message();
        int nfull;
        int i;
        if ($urandom_range(99) < 80) begin
            nfull = ($urandom_range(19) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 0);
            for (i = 0; i < nfull; i++)
                send_word($urandom, MM3_FULL_COUNT, 1'b0);
            send_word($urandom, 3'($urandom_range(4)), 1'b1);
        end else begin
            nfull = $urandom_range(5, 1);
            for (i = 0; i < nfull; i++)
                send_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty message, full-word extremes, one to three byte tails with junk in the
    // unused bytes, a short word without tlast, and a zero-count closing word.
    task automatic test_empty_and_partial();
        int c;
        send_word($urandom, 3'd0, 1'b1);
        send_word(32'hffffffff, MM3_FULL_COUNT, 1'b1);
        send_word(32'h00000000, MM3_FULL_COUNT, 1'b1);
        for (c = 1; c < 4; c++)
            send_word(32'hffffffff, 3'(c), 1'b1);
        send_word($urandom, 3'd2, 1'b0);
        send_word($urandom, MM3_FULL_COUNT, 1'b0);
        send_word($urandom, 3'd0, 1'b1);
    endtask

    // Counts five to seven must act as four.
    task automatic test_count_clamp();
        send_word($urandom, 3'd5, 1'b0);
        send_word($urandom, 3'd6, 1'b0);
        send_word($urandom, 3'd7, 1'b1);
        send_word(32'h80000001, 3'd7, 1'b1);
    endtask

    // Seed at both extremes: all ones, then zero.
    task automatic test_seed_extremes();
        write_seed(32'hffffffff);
        send_word($urandom, 3'd0, 1'b1);
        send_word($urandom, MM3_FULL_COUNT, 1'b0);
        send_word($urandom, MM3_FULL_COUNT, 1'b0);
        send_word($urandom, 3'd3, 1'b1);
        write_seed(32'h00000000);
        send_word(32'h12345678, MM3_FULL_COUNT, 1'b1);
    endtask

    // Pause the sender until every owed hash is out, then resume.
    task automatic test_drain_pause();
        send_word($urandom, MM3_FULL_COUNT, 1'b0);
        send_word($urandom, 3'd1, 1'b1);
        hold_until_drained();
        send_word($urandom, MM3_FULL_COUNT, 1'b1);
    endtask

    // A phase of random messages under one seed; close any open message at the end.
    task automatic test_random_stream(int target_words, logic [31:0] seed_val);
        int start;
        write_seed(seed_val);
        start = words_sent;
        while (words_sent - start < target_words) begin
            if ($urandom_range(29) == 0)
                hold_until_drained();
            send_random_message();
        end
        if (in_msg)
            send_word($urandom, 3'd0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_partial();
        test_count_clamp();
        test_seed_extremes();
        test_drain_pause();
        test_random_stream(450, $urandom);
        test_random_stream(450, 32'h00000000);
        // Long stretch with no idling on either side.
        calm = 1'b1;
        test_random_stream(350, 32'hffffffff);
        calm = 1'b0;
        test_random_stream(450, $urandom);

        hold_until_drained();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Receiver: stall at random except during the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every accepted hash word against the oldest owed hash.
    always @(posedge aclk) begin : check_hash
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (hash_q.size() == 0) begin
                $error("hash_value: no hash expected, actual %08h", m_tdata);
                errors++;
            end else begin
                want = hash_q.pop_front();
                if (m_tdata !== want) begin
                    $error("hash_value: expected %08h, actual %08h", want, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
